@@ rtl/canonical_kmer_extractor_unit_assert.svh @@
// assertion macros shared by the canonical k-mer extractor rtl
`ifndef CANONICAL_KMER_EXTRACTOR_UNIT_ASSERT_SVH
`define CANONICAL_KMER_EXTRACTOR_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define CKE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("canonical kmer extractor check failed");

// next-cycle implication, clocked on clk, off while rst_n is low
`define CKE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("canonical kmer extractor check failed");

`endif

@@ rtl/cke_pkg.sv @@
// shared types, constants and the base translation table of the k-mer extractor
`default_nettype none

package cke_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned PosW    = 32;
  localparam int unsigned KLenW   = 5;
  localparam int unsigned SeenW   = 5;
  localparam int unsigned CharW   = 8;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;

  // saturation point of the fill count and reset k-mer length
  localparam logic [SeenW-1:0] SeenMax  = 5'd31;
  localparam logic [KLenW-1:0] KLenRst  = 5'd31;
  localparam logic [KLenW-1:0] KLenMin  = 5'd1;

  // register map
  typedef enum logic [CfgAddrW-1:0] {
    REG_KMER_LENGTH = 2'd0
  } reg_addr_t;

  typedef logic [1:0] base_t;

  // selected word and its orientation
  typedef struct packed {
    logic [WordW-1:0] mer;
    logic             is_reverse;
  } sel_result_t;

  // dna character to 2-bit code, unknown bytes give a
  function automatic base_t base_code(input logic [CharW-1:0] ch);
    base_t code;
    unique case (ch)
      8'h63, 8'h43, 8'h62, 8'h42, 8'h79, 8'h59: code = 2'd1; // c b y
      8'h67, 8'h47, 8'h73, 8'h53, 8'h6b, 8'h4b: code = 2'd2; // g s k
      8'h74, 8'h54:                             code = 2'd3; // t
      default:                                  code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

@@ rtl/cke_select.sv @@
// left-aligns the forward word, masks the reverse word and picks the smaller
`default_nettype none

module cke_select (
  input  wire logic [cke_pkg::WordW-1:0] fwd_word,
  input  wire logic [cke_pkg::WordW-1:0] rev_word,
  input  wire logic [cke_pkg::KLenW-1:0] kmer_len,  // already forced to 1..31
  output cke_pkg::sel_result_t           result
);

  logic [6:0]                  dead_wide;
  logic [5:0]                  dead;
  logic [cke_pkg::WordW-1:0]   mask;
  logic [cke_pkg::WordW-1:0]   fwd_aligned;
  logic [cke_pkg::WordW-1:0]   rev_flagged;

  // unused low bits below the k-mer, 2..62
  assign dead_wide = 7'd64 - {1'b0, kmer_len, 1'b0};
  assign dead      = dead_wide[5:0];

  // align and mask both words
  assign mask        = {cke_pkg::WordW{1'b1}} << dead;
  assign fwd_aligned = fwd_word << dead;
  assign rev_flagged = (rev_word & mask) | {{(cke_pkg::WordW-1){1'b0}}, 1'b1};

  // forward wins only when strictly smaller
  always_comb begin
    if (fwd_aligned < rev_flagged) begin
      result.mer        = fwd_aligned;
      result.is_reverse = 1'b0;
    end else begin
      result.mer        = rev_flagged;
      result.is_reverse = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/canonical_kmer_extractor_unit.sv @@
// Canonical k-mer extractor: takes one sequence character per word, keeps the
// rolling forward and reverse-complement words, and once kmer_length bases of
// the current sequence are in, returns the smaller word with its start
// position. Throughput is one character per clock unless the output stalls.
// An accepted character passes through the register stages: the first holds the
// updated rolling words, fill count and position, the second holds the
// aligned, compared result; the align shift and 64-bit compare between them
// set the clock. Characters that do not complete a k-mer produce no result.
// kmer_length sits at byte address 0 of the configuration port; 0 is treated
// as 1. The user must write it only while idle; the block does not enforce this.
`default_nettype none

module canonical_kmer_extractor_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,

  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] base_char
  input  wire logic [0:0]  in_tuser,   // [0] new_sequence

  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [95:0]      out_tdata,  // [63:0] canonical_mer, [95:64] mer_position
  output logic [0:0]       out_tuser   // [0] is_reverse
);

  logic [cke_pkg::KLenW-1:0] kmer_len_r;
  logic                      cfg_wr;

  logic [cke_pkg::WordW-1:0] fwd_r, rev_r;
  logic [cke_pkg::WordW-1:0] fwd_base, rev_base, fwd_nxt, rev_nxt;
  logic [cke_pkg::SeenW-1:0] seen_r, seen_base, seen_nxt;
  logic [cke_pkg::PosW-1:0]  pos_r, pos_base, pos_nxt;
  logic [cke_pkg::KLenW-1:0] k_eff;
  cke_pkg::base_t            code;
  logic                      emit;

  logic                      s1_valid_r, s1_emit_r;
  logic [cke_pkg::PosW-1:0]  s1_pos_r;
  logic [cke_pkg::KLenW-1:0] s1_k_r;

  logic                      out_valid_r, out_rev_r;
  logic [cke_pkg::WordW-1:0] out_mer_r;
  logic [cke_pkg::PosW-1:0]  out_pos_r;

  logic                      adv_out, in_acc, load_out;
  cke_pkg::sel_result_t      sel;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite
                  && (cfg_paddr == cke_pkg::REG_KMER_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kmer_len_r <= cke_pkg::KLenRst;
    end else if (cfg_wr) begin
      kmer_len_r <= cfg_pwdata[cke_pkg::KLenW-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == cke_pkg::REG_KMER_LENGTH) begin
      cfg_prdata = {{(cke_pkg::CfgDataW-cke_pkg::KLenW){1'b0}}, kmer_len_r};
    end
  end

  // handshake: stage one frees up whenever the output register can move
  assign adv_out   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || adv_out;
  assign in_acc    = in_tvalid && in_tready;
  assign load_out  = adv_out && s1_valid_r && s1_emit_r;

  // rolling update for the incoming character
  always_comb begin
    code      = cke_pkg::base_code(in_tdata);
    k_eff     = (kmer_len_r == '0) ? cke_pkg::KLenMin : kmer_len_r;
    fwd_base  = in_tuser[0] ? '0 : fwd_r;
    rev_base  = in_tuser[0] ? '0 : rev_r;
    seen_base = in_tuser[0] ? '0 : seen_r;
    pos_base  = in_tuser[0] ? '0 : pos_r;
    fwd_nxt   = {fwd_base[cke_pkg::WordW-3:0], code};
    rev_nxt   = {~code, rev_base[cke_pkg::WordW-1:2]};
    seen_nxt  = (seen_base == cke_pkg::SeenMax) ? seen_base : seen_base + 1'b1;
    emit      = (seen_nxt >= k_eff);
    pos_nxt   = emit ? pos_base + 1'b1 : pos_base;
  end

  // stage one: rolling state plus the word heading for compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r      <= '0;
      rev_r      <= '0;
      seen_r     <= '0;
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        fwd_r      <= fwd_nxt;
        rev_r      <= rev_nxt;
        seen_r     <= seen_nxt;
        pos_r      <= pos_nxt;
        s1_valid_r <= 1'b1;
        s1_emit_r  <= emit;
      end else if (adv_out) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r <= pos_base;
      s1_k_r   <= k_eff;
    end
  end

  cke_select u_select (
    .fwd_word (fwd_r),
    .rev_word (rev_r),
    .kmer_len (s1_k_r),
    .result   (sel)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r && s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_mer_r <= sel.mer;
      out_rev_r <= sel.is_reverse;
      out_pos_r <= s1_pos_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_pos_r, out_mer_r};
  assign out_tuser[0] = out_rev_r;

  `include "canonical_kmer_extractor_unit_assert.svh"

  // orientation flag in the word agrees with the reported orientation
  `CKE_ASSERT_NOW(a_flag_matches, out_tvalid, out_tdata[0] == out_tuser[0])
  // a new sequence restarts the fill count at one base
  `CKE_ASSERT_NEXT(a_new_seq_fill, in_acc && in_tuser[0], seen_r == 5'd1)
  // fill count steps by one until it saturates
  `CKE_ASSERT_NEXT(a_fill_step, in_acc && !in_tuser[0] && (seen_r != cke_pkg::SeenMax),
                   seen_r == $past(seen_r) + 5'd1)
  // an emitting word in stage one reaches the output when it may move
  `CKE_ASSERT_NEXT(a_emit_reaches_out, s1_valid_r && s1_emit_r && adv_out, out_tvalid)
  // a non-emitting word never produces output
  `CKE_ASSERT_NEXT(a_no_emit_no_out, adv_out && !(s1_valid_r && s1_emit_r), !out_tvalid)

endmodule

`default_nettype wire

@@ tb/kmer_result_checker.sv @@
// checker for the k-mer extractor: tracks config, predicts each result word and compares
module kmer_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] base_char
  input  logic [0:0]  in_tuser,   // [0] new_sequence
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,  // [63:0] canonical_mer, [95:64] mer_position
  input  logic [0:0]  out_tuser,  // [0] is_reverse
  output int          error_count,
  output int          words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] mer;
    logic [31:0] pos;
    logic        rev;
  } kmer_hit_t;

  // own copy of the rolling state and the length register
  logic [63:0] fwd_bases;
  logic [63:0] rc_bases;
  logic [4:0]  fill;
  logic [4:0]  klen;
  logic [31:0] start_pos;
  kmer_hit_t   expected_kmers[$];

  initial begin
    error_count   = 0;
    words_pending = 0;
  end

  // fixed dna translation, anything unlisted is code 0
  function automatic logic [1:0] dna_code(input logic [7:0] ch);
    case (ch)
      "c", "C", "b", "B", "y", "Y": return 2'd1;
      "g", "G", "s", "S", "k", "K": return 2'd2;
      "t", "T":                     return 2'd3;
      default:                      return 2'd0;
    endcase
  endfunction

  // shift one base into both words, return 1 when a k-mer is complete
  function automatic bit roll_base(input logic [7:0] ch, input logic fresh,
                                   output kmer_hit_t hit);
    logic [1:0]  code;
    logic [4:0]  k;
    int unsigned dead;
    logic [63:0] keep;
    logic [63:0] fwd_mer;
    logic [63:0] rc_mer;
    code = dna_code(ch);
    k    = (klen == 5'd0) ? 5'd1 : klen;
    dead = 64 - 2 * k;
    hit  = '0;
    if (fresh) begin
      fwd_bases = '0;
      rc_bases  = '0;
      fill      = '0;
      start_pos = '0;
    end
    fwd_bases = {fwd_bases[61:0], code};
    rc_bases  = {~code, rc_bases[63:2]};
    if (fill < 5'd31) fill = fill + 5'd1;
    if (fill < k) return 1'b0;
    keep    = {64{1'b1}} << dead;
    fwd_mer = (fwd_bases << dead) & keep;
    rc_mer  = (rc_bases & keep) | 64'd1;
    if (fwd_mer < rc_mer) begin
      hit.mer = fwd_mer;
      hit.rev = 1'b0;
    end else begin
      hit.mer = rc_mer;
      hit.rev = 1'b1;
    end
    hit.pos   = start_pos;
    start_pos = start_pos + 32'd1;
    return 1'b1;
  endfunction

  // watch all three ports at each edge
  always @(posedge clk) begin
    kmer_hit_t hit;
    kmer_hit_t got;
    kmer_hit_t want;
    if (!rst_n) begin
      fwd_bases = '0;
      rc_bases  = '0;
      fill      = '0;
      start_pos = '0;
      klen      = 5'd31;
      expected_kmers.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == cke_pkg::REG_KMER_LENGTH)
        klen = cfg_pwdata[4:0];
      if (in_tvalid && in_tready && roll_base(in_tdata, in_tuser[0], hit))
        expected_kmers.insert(expected_kmers.size(), hit);
      if (out_tvalid && out_tready) begin
        got.mer = out_tdata[63:0];
        got.pos = out_tdata[95:64];
        got.rev = out_tuser[0];
        if (expected_kmers.size() == 0) begin
          if (error_count < 10)
            $display("%0t: result word with none expected: mer %h pos %0d rev %b",
                     $realtime, got.mer, got.pos, got.rev);
          error_count++;
        end else begin
          want = expected_kmers.pop_front();
          if (got.mer !== want.mer || got.pos !== want.pos || got.rev !== want.rev) begin
            if (error_count < 10)
              $display("%0t: mismatch mer %h/%h pos %0d/%0d rev %b/%b (exp/got)",
                       $realtime, want.mer, got.mer, want.pos, got.pos,
                       want.rev, got.rev);
            error_count++;
          end
        end
      end
    end
    words_pending <= expected_kmers.size();
  end

endmodule

@@ tb/canonical_kmer_extractor_unit_test.sv @@
// top of the k-mer extractor testbench: clock, reset, stimulus, receiver and verdict
module canonical_kmer_extractor_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] base_char
  logic [0:0]  in_tuser = '0;   // [0] new_sequence
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;       // [63:0] canonical_mer, [95:64] mer_position
  logic [0:0]  out_tuser;       // [0] is_reverse
  int          error_count;
  int          words_pending;

  // idle limit shared by sender and receiver, plus a receiver-only hold-off
  int    idle_max = 0;
  int    rx_hold_cycles = 0;
  string dna_text = "ACGTacgtBYSKbysk";
  string probe_text = "cCbByYgGsSkKtTa";

  canonical_kmer_extractor_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  kmer_result_checker kmer_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_pready    (cfg_pready),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .error_count   (error_count),
    .words_pending (words_pending)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // at least half the draws are zero, so busy and quiet runs mix
  function automatic int idle_draw();
    return ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(0, idle_max);
  endfunction

  // mostly dna letters, some arbitrary bytes
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 9) < 8) return dna_text[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  // result side: stall per word, plus an occasional long hold-off
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = idle_draw();
      if (rx_hold_cycles > 0) begin
        stall = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // register write: setup then access
  task automatic set_kmer_length(input logic [4:0] len);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= cke_pkg::REG_KMER_LENGTH;
    cfg_pwdata  <= {(($urandom_range(0, 1) == 1) ? 27'($urandom) : 27'd0), len};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // offer one character and wait for it to be taken
  task automatic send_base(input logic [7:0] ch, input logic fresh);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= fresh;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop sending until every predicted word is back, then cover pipeline latency
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int          phase_k[8];
    int          k_eff;
    int          len;
    int          sent;
    bit          lead;
    phase_k = '{31, 2, 0, 17, 1, 31, 9, 30};
    phase_k[3] = $urandom_range(3, 29);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every table entry and odd bytes with single-base k-mers
    idle_max = 3;
    set_kmer_length(5'd1);
    for (int i = 0; i < probe_text.len(); i++)
      send_base(probe_text[i], i == 0);
    send_base(8'h00, 1'b0);
    send_base(8'hff, 1'b0);
    send_base(8'h80, 1'b0);
    settle();

    // zero length behaves as one
    set_kmer_length(5'd0);
    send_base("T", 1'b1);
    send_base("a", 1'b0);
    send_base(8'hff, 1'b0);
    settle();

    // nothing until three bases of the new sequence are in
    set_kmer_length(5'd3);
    send_base("G", 1'b1);
    send_base("C", 1'b0);
    send_base("A", 1'b0);
    send_base("t", 1'b0);
    settle();

    // random sequences under several lengths, some continuing across a change
    for (int p = 0; p < 8; p++) begin
      set_kmer_length(5'(phase_k[p]));
      k_eff    = (phase_k[p] == 0) ? 1 : phase_k[p];
      idle_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 12 : 4);
      if (p == 3) rx_hold_cycles = 300;
      sent = 0;
      lead = 1'b1;
      while (sent < 175) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 40)
                                          : $urandom_range(k_eff, k_eff + 45);
        for (int i = 0; i < len; i++)
          send_base(pick_char(), (i == 0) && (!lead || $urandom_range(0, 1) == 1));
        sent += len;
        lead = 1'b0;
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (error_count == 0 && words_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
